// ===== hdl/rmedf_pkg.sv =====
package rmedf_pkg;

  // Task row size and derived widths
  localparam int MAX_TASKS  = 4;
  localparam int TASK_IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

  // Register and field widths
  localparam int CNT_W      = 3;
  localparam int CNT_EXT_W  = CNT_W + 1;
  localparam int CFG_IDX_W  = $clog2(2 + MAX_TASKS);
  localparam int CFG_DATA_W = 16;
  localparam int PER_W      = 8;
  localparam int EXEC_W     = 8;
  localparam int TIME_W     = 32;
  localparam int OUT_IDX_W  = 2;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 40;

  // Register map
  localparam logic [CFG_IDX_W-1:0] REG_SCHED_MODE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TASK_COUNT = CFG_IDX_W'(1);
  localparam int                   REG_TASK_WORD0 = 2;

  // Reset value of a task word: execution 1, period 1
  localparam logic [CFG_DATA_W-1:0] TASK_WORD_RST = CFG_DATA_W'(257);

  // Selection word handed from cell to cell
  typedef struct packed {
    logic                  vld;
    logic [TASK_IDX_W-1:0] idx;
    logic [TIME_W-1:0]     key;
  } tok_t;

  // Per-tick control broadcast to every cell
  typedef struct packed {
    logic                  clr;
    logic                  rel;
    logic                  commit;
    logic                  mode;
    logic [TIME_W-1:0]     now;
    logic                  pick_vld;
    logic [TASK_IDX_W-1:0] pick_idx;
  } cell_ctl_t;

  // Period field of a task word, zero read as one
  function automatic logic [PER_W-1:0] eff_period(input logic [CFG_DATA_W-1:0] word);
    logic [PER_W-1:0] p;
    p = word[PER_W-1:0];
    return (p == '0) ? PER_W'(1) : p;
  endfunction

endpackage

// ===== hdl/rmedf_cell.sv =====
module rmedf_cell (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rmedf_pkg::cell_ctl_t            ctl_i,
  input  logic                            active_i,
  input  logic [rmedf_pkg::TASK_IDX_W-1:0] cell_idx_i,
  input  logic [rmedf_pkg::CFG_DATA_W-1:0] word_i,
  input  rmedf_pkg::tok_t                 tok_i,
  output rmedf_pkg::tok_t                 tok_o
);
  import rmedf_pkg::*;

  logic [PER_W-1:0]  phase_q, phase_d;
  logic [EXEC_W-1:0] budget_q, budget_d;
  logic [TIME_W-1:0] dl_q, dl_d;
  tok_t              tok_q, tok_d;

  logic [PER_W-1:0]  per;
  logic [EXEC_W-1:0] exec_t;
  logic [TIME_W-1:0] key;
  logic [PER_W:0]    phase_nx;
  logic              ready;
  logic              wins;

  assign per      = eff_period(word_i);
  assign exec_t   = word_i[CFG_DATA_W-1:PER_W];
  assign phase_nx = {1'b0, phase_q} + (PER_W+1)'(1);

  // Ready while budget remains and the deadline lies ahead
  assign ready = (budget_q != '0) && (ctl_i.now < dl_q);
  assign key   = ctl_i.mode ? dl_q : TIME_W'(per);
  // Strictly smaller key wins, so ties stay with the lower index upstream
  assign wins  = active_i && ready && (!tok_i.vld || (key < tok_i.key));

  // Merge own candidate into the passing word
  always_comb begin
    tok_d = tok_i;
    if (wins) begin
      tok_d.vld = 1'b1;
      tok_d.idx = cell_idx_i;
      tok_d.key = key;
    end
  end

  // Clear, release, then spend and advance at commit
  always_comb begin
    phase_d  = phase_q;
    budget_d = budget_q;
    dl_d     = dl_q;
    if (ctl_i.clr) begin
      phase_d  = '0;
      budget_d = '0;
      dl_d     = '0;
    end else if (ctl_i.rel) begin
      if (active_i && (phase_q == '0)) begin
        budget_d = exec_t;
        dl_d     = ctl_i.now + TIME_W'(per);
      end
    end else if (ctl_i.commit && active_i) begin
      phase_d = (phase_nx >= {1'b0, per}) ? '0 : phase_nx[PER_W-1:0];
      if (ctl_i.pick_vld && (ctl_i.pick_idx == cell_idx_i)) begin
        budget_d = budget_q - EXEC_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= '0;
      budget_q <= '0;
      dl_q     <= '0;
      tok_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      budget_q <= budget_d;
      dl_q     <= dl_d;
      tok_q    <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// ===== hdl/rmedf_lcm.sv =====
module rmedf_lcm (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          start_i,
  input  logic [rmedf_pkg::CNT_EXT_W-1:0]               cnt_i,
  input  logic [rmedf_pkg::MAX_TASKS-1:0][rmedf_pkg::PER_W-1:0] per_i,
  output logic                                          done_o,
  output logic [rmedf_pkg::TIME_W-1:0]                  hyper_o
);
  import rmedf_pkg::*;

  localparam int BIT_W = $clog2(TIME_W);

  typedef enum logic [2:0] {
    L_IDLE = 3'b001,
    L_MOD  = 3'b010,
    L_STEP = 3'b100
  } lcm_state_e;

  lcm_state_e         state_q, state_d;
  logic [TIME_W-1:0]  l_q, l_d;
  logic [TIME_W-1:0]  m_q, m_d;
  logic [PER_W-1:0]   rem_q, rem_d;
  logic [PER_W-1:0]   acc_q, acc_d;
  logic [BIT_W-1:0]   bit_q, bit_d;
  logic [CNT_EXT_W-1:0] k_q, k_d;
  logic               done_q, done_d;

  logic [PER_W-1:0]   p;
  logic [PER_W:0]     r9, r9s, a9, a9s;
  logic [TIME_W:0]    sum;
  logic [CNT_EXT_W-1:0] k_nx;

  assign p    = per_i[k_q[TASK_IDX_W-1:0]];
  // One bit of the running remainder of l by p
  assign r9   = {rem_q, l_q[bit_q]};
  assign r9s  = (r9 >= {1'b0, p}) ? (r9 - {1'b0, p}) : r9;
  // Next multiple of l and its residue
  assign sum  = {1'b0, m_q} + {1'b0, l_q};
  assign a9   = {1'b0, acc_q} + {1'b0, rem_q};
  assign a9s  = (a9 >= {1'b0, p}) ? (a9 - {1'b0, p}) : a9;
  assign k_nx = k_q + CNT_EXT_W'(1);

  always_comb begin
    state_d = state_q;
    l_d     = l_q;
    m_d     = m_q;
    rem_d   = rem_q;
    acc_d   = acc_q;
    bit_d   = bit_q;
    k_d     = k_q;
    done_d  = 1'b0;
    unique case (state_q)
      L_IDLE: begin
        if (start_i) begin
          l_d     = TIME_W'(1);
          k_d     = '0;
          rem_d   = '0;
          bit_d   = BIT_W'(TIME_W - 1);
          state_d = L_MOD;
        end
      end
      L_MOD: begin
        rem_d = r9s[PER_W-1:0];
        if (bit_q == '0) begin
          m_d     = l_q;
          acc_d   = r9s[PER_W-1:0];
          state_d = L_STEP;
        end else begin
          bit_d = bit_q - BIT_W'(1);
        end
      end
      L_STEP: begin
        if (acc_q == '0) begin
          // m is the least multiple of l that p divides
          l_d = m_q;
          k_d = k_nx;
          if (k_nx == cnt_i) begin
            done_d  = 1'b1;
            state_d = L_IDLE;
          end else begin
            rem_d   = '0;
            bit_d   = BIT_W'(TIME_W - 1);
            state_d = L_MOD;
          end
        end else if (sum[TIME_W]) begin
          // Saturate on overflow
          l_d     = '1;
          done_d  = 1'b1;
          state_d = L_IDLE;
        end else begin
          m_d   = sum[TIME_W-1:0];
          acc_d = a9s[PER_W-1:0];
        end
      end
      default: state_d = L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      l_q     <= TIME_W'(1);
      m_q     <= '0;
      rem_q   <= '0;
      acc_q   <= '0;
      bit_q   <= '0;
      k_q     <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      l_q     <= l_d;
      m_q     <= m_d;
      rem_q   <= rem_d;
      acc_q   <= acc_d;
      bit_q   <= bit_d;
      k_q     <= k_d;
      done_q  <= done_d;
    end
  end

  assign done_o  = done_q;
  assign hyper_o = l_q;

endmodule

// ===== hdl/rm_edf_tick_scheduler.sv =====
// Periodic task tick scheduler, rate monotonic or earliest deadline first.
// Each input word is one time slot and yields one output word with the slot
// time, the task that ran, an idle flag (tuser) and the hyper-period end (tlast).
// A tick has a release step, then a selection word walks the row of task
// cells one cell per cycle, then a commit step. A tick with restart set
// first recomputes the hyper-period as the LCM of the periods in use, one
// task after another: a bit-serial remainder of the running LCM by the
// period, then a search over its multiples. A new word is taken while the
// previous result still waits at the output register. Registers are written
// through cfg_we_i/cfg_idx_i/cfg_data_i; the user must do so only while
// idle, as the block itself does not enforce it.
module rm_edf_tick_scheduler (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [rmedf_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rmedf_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // input words
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic [rmedf_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,  // [0] restart
  // result words
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  output logic [rmedf_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,  // [31:0] time_now, [33:32] task_index
  output logic                                 m_axis_tuser_o,  // [0] idle
  output logic                                 m_axis_tlast_o   // period_end
);
  import rmedf_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_HYPER  = 5'b00010,
    S_REL    = 5'b00100,
    S_SCAN   = 5'b01000,
    S_COMMIT = 5'b10000
  } state_e;

  localparam logic [TASK_IDX_W-1:0] SCAN_LAST = TASK_IDX_W'(MAX_TASKS - 1);

  // Configuration registers
  logic                                 mode_q;
  logic [CNT_W-1:0]                     cnt_q;
  logic [MAX_TASKS-1:0][CFG_DATA_W-1:0] word_q;

  // Schedule state
  state_e                state_q, state_d;
  logic [TIME_W-1:0]     tick_q, tick_d;
  logic [TIME_W-1:0]     hyper_q, hyper_d;
  logic [TASK_IDX_W-1:0] scan_q, scan_d;

  // Output register
  logic                  out_vld_q, out_vld_d;
  logic [TIME_W-1:0]     out_time_q, out_time_d;
  logic [OUT_IDX_W-1:0]  out_idx_q, out_idx_d;
  logic                  out_idle_q, out_idle_d;
  logic                  out_end_q, out_end_d;

  logic [CNT_EXT_W-1:0]             cnt_eff;
  logic [MAX_TASKS-1:0][PER_W-1:0]  per;
  tok_t                             tok [MAX_TASKS+1];
  tok_t                             pick;
  cell_ctl_t                        ctl;
  logic                             lcm_start;
  logic                             lcm_done;
  logic [TIME_W-1:0]                lcm_hyper;
  logic                             clr, rel, commit;
  logic                             out_free;
  logic                             wrap;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      cnt_q  <= CNT_W'(1);
      for (int k = 0; k < MAX_TASKS; k++) begin
        word_q[k] <= TASK_WORD_RST;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_SCHED_MODE) begin
        mode_q <= cfg_data_i[0];
      end
      if (cfg_idx_i == REG_TASK_COUNT) begin
        cnt_q <= cfg_data_i[CNT_W-1:0];
      end
      for (int k = 0; k < MAX_TASKS; k++) begin
        if (cfg_idx_i == CFG_IDX_W'(REG_TASK_WORD0 + k)) begin
          word_q[k] <= cfg_data_i;
        end
      end
    end
  end

  // Clamp the task count to one..MAX_TASKS
  always_comb begin
    cnt_eff = {1'b0, cnt_q};
    if (cnt_q == '0) begin
      cnt_eff = CNT_EXT_W'(1);
    end else if ({1'b0, cnt_q} > CNT_EXT_W'(MAX_TASKS)) begin
      cnt_eff = CNT_EXT_W'(MAX_TASKS);
    end
  end

  // Row of task cells, selection word enters empty at cell zero
  assign tok[0] = '0;

  for (genvar k = 0; k < MAX_TASKS; k++) begin : g_cell
    assign per[k] = eff_period(word_q[k]);

    rmedf_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .active_i   (CNT_EXT_W'(k) < cnt_eff),
      .cell_idx_i (TASK_IDX_W'(k)),
      .word_i     (word_q[k]),
      .tok_i      (tok[k]),
      .tok_o      (tok[k+1])
    );
  end

  assign pick = tok[MAX_TASKS];

  rmedf_lcm u_lcm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lcm_start),
    .cnt_i   (cnt_eff),
    .per_i   (per),
    .done_o  (lcm_done),
    .hyper_o (lcm_hyper)
  );

  // Broadcast control to the cells
  always_comb begin
    ctl.clr      = clr;
    ctl.rel      = rel;
    ctl.commit   = commit;
    ctl.mode     = mode_q;
    ctl.now      = tick_q;
    ctl.pick_vld = pick.vld;
    ctl.pick_idx = pick.idx;
  end

  assign out_free = !out_vld_q || m_axis_tready_i;
  assign wrap     = ({1'b0, tick_q} + (TIME_W+1)'(1)) >= {1'b0, hyper_q};

  // Tick sequencer
  always_comb begin
    state_d    = state_q;
    tick_d     = tick_q;
    hyper_d    = hyper_q;
    scan_d     = scan_q;
    out_vld_d  = out_vld_q && !m_axis_tready_i;
    out_time_d = out_time_q;
    out_idx_d  = out_idx_q;
    out_idle_d = out_idle_q;
    out_end_d  = out_end_q;
    lcm_start  = 1'b0;
    clr        = 1'b0;
    rel        = 1'b0;
    commit     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          if (s_axis_tdata_i[0]) begin
            clr       = 1'b1;
            tick_d    = '0;
            lcm_start = 1'b1;
            state_d   = S_HYPER;
          end else begin
            state_d = S_REL;
          end
        end
      end
      S_HYPER: begin
        if (lcm_done) begin
          hyper_d = lcm_hyper;
          state_d = S_REL;
        end
      end
      S_REL: begin
        rel     = 1'b1;
        scan_d  = '0;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (scan_q == SCAN_LAST) begin
          state_d = S_COMMIT;
        end else begin
          scan_d = scan_q + TASK_IDX_W'(1);
        end
      end
      S_COMMIT: begin
        // Hold until the output register is free
        if (out_free) begin
          commit     = 1'b1;
          out_vld_d  = 1'b1;
          out_time_d = tick_q;
          out_idx_d  = pick.vld ? OUT_IDX_W'(pick.idx) : '0;
          out_idle_d = !pick.vld;
          out_end_d  = wrap;
          tick_d     = wrap ? '0 : (tick_q + TIME_W'(1));
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      tick_q    <= '0;
      hyper_q   <= TIME_W'(1);
      scan_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      tick_q    <= tick_d;
      hyper_q   <= hyper_d;
      scan_q    <= scan_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_time_q <= out_time_d;
    out_idx_q  <= out_idx_d;
    out_idle_q <= out_idle_d;
    out_end_q  <= out_end_d;
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{(OUT_DATA_W - TIME_W - OUT_IDX_W){1'b0}}, out_idx_q, out_time_q};
  assign m_axis_tuser_o  = out_idle_q;
  assign m_axis_tlast_o  = out_end_q;

endmodule

// ===== hdl/rmedf_checker.sv =====
module rmedf_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid_i,
  input logic                             s_axis_tready_o,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [rmedf_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic                             m_axis_tuser_o,
  input logic                             m_axis_tlast_o
);
  import rmedf_pkg::*;

  // One tick in flight: no new word right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input taken twice in a row");

  // Idle slots report task zero
  a_idle_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |->
      (m_axis_tdata_o[TIME_W+OUT_IDX_W-1:TIME_W] == '0))
    else $error("idle slot with nonzero task index");

  // A result never appears in the cycle right after an accept
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> !$past(s_axis_tvalid_i && s_axis_tready_o))
    else $error("result too soon after accept");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
       && $stable(m_axis_tlast_o)))
    else $error("stalled result changed");

endmodule

bind rm_edf_tick_scheduler rmedf_checker u_rmedf_checker (.*);

// ===== verif/tb_rm_edf_tick_scheduler.sv =====
module tb_rm_edf_tick_scheduler;
  timeunit 1ns;
  timeprecision 1ps;

  import rmedf_pkg::*;

  localparam int CYCLE_LIMIT     = 4_000_000;
  localparam int DRAIN_LIMIT     = 20_000;
  localparam int REPORT_MAX      = 10;
  localparam int REG_SPARE_FIRST = REG_TASK_WORD0 + MAX_TASKS;
  localparam int REG_LAST        = (1 << CFG_IDX_W) - 1;

  typedef enum logic {
    SCHED_RM  = 1'b0,
    SCHED_EDF = 1'b1
  } sched_mode_e;

  // One scheduler slot as it leaves the block
  typedef struct packed {
    logic [TIME_W-1:0]    time_now;
    logic [OUT_IDX_W-1:0] task_index;
    logic                 idle;
    logic                 period_end;
  } slot_t;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i       = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i      = '0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i  = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                  m_axis_tuser_o;
  logic                  m_axis_tlast_o;

  rm_edf_tick_scheduler dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),   // [0] restart
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),   // [31:0] time_now, [33:32] task_index
    .m_axis_tuser_o  (m_axis_tuser_o),   // [0] idle
    .m_axis_tlast_o  (m_axis_tlast_o)    // period_end
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow of the scheduler registers and task state
  sched_mode_e          sh_mode;
  logic [CNT_W-1:0]     sh_count;
  logic [CFG_DATA_W-1:0] sh_word [MAX_TASKS];
  logic [TIME_W-1:0]    sh_slot_time;
  logic [TIME_W-1:0]    sh_hyper;
  logic [PER_W-1:0]     sh_phase [MAX_TASKS];
  logic [EXEC_W-1:0]    sh_budget [MAX_TASKS];
  logic [TIME_W-1:0]    sh_deadline [MAX_TASKS];

  slot_t slot_q [$];

  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int mismatch_cnt  = 0;
  int ticks_sent    = 0;
  int restarts_sent = 0;
  int slots_seen    = 0;
  int idle_seen     = 0;
  int wraps_seen    = 0;
  int settings_used = 0;
  int cycle_cnt     = 0;

  function automatic int tasks_in_use();
    int c;
    c = int'(sh_count);
    if (c == 0) c = 1;
    if (c > MAX_TASKS) c = MAX_TASKS;
    return c;
  endfunction

  function automatic int period_of(input int k);
    int p;
    p = int'(sh_word[k][PER_W-1:0]);
    return (p == 0) ? 1 : p;
  endfunction

  // LCM of the periods in use, saturated to the time width
  function automatic logic [TIME_W-1:0] hyper_of_periods();
    longint unsigned l, a, b, t;
    l = 1;
    for (int k = 0; k < tasks_in_use(); k++) begin
      a = l;
      b = longint'(period_of(k));
      while (b != 0) begin
        t = a % b;
        a = b;
        b = t;
      end
      l = (l / a) * longint'(period_of(k));
      if (l > 64'hFFFF_FFFF) return '1;
    end
    return l[TIME_W-1:0];
  endfunction

  // Advance the shadow scheduler by one slot and return what it should emit
  function automatic slot_t schedule_slot(input logic restart);
    slot_t s;
    int    n;
    int    pick;
    int    nx;
    if (restart) begin
      sh_slot_time = '0;
      for (int k = 0; k < MAX_TASKS; k++) begin
        sh_phase[k]    = '0;
        sh_budget[k]   = '0;
        sh_deadline[k] = '0;
      end
      sh_hyper = hyper_of_periods();
    end
    n = tasks_in_use();
    // release
    for (int k = 0; k < n; k++) begin
      if (sh_phase[k] == '0) begin
        sh_budget[k]   = sh_word[k][CFG_DATA_W-1:PER_W];
        sh_deadline[k] = sh_slot_time + TIME_W'(period_of(k));
      end
    end
    // select, ties to the lower index
    pick = -1;
    for (int k = 0; k < n; k++) begin
      if (sh_budget[k] != '0 && sh_slot_time < sh_deadline[k]) begin
        if (pick < 0) begin
          pick = k;
        end else if (sh_mode == SCHED_RM) begin
          if (period_of(k) < period_of(pick)) pick = k;
        end else if (sh_deadline[k] < sh_deadline[pick]) begin
          pick = k;
        end
      end
    end
    if (pick >= 0) sh_budget[pick] = sh_budget[pick] - 1'b1;
    for (int k = 0; k < n; k++) begin
      nx = int'(sh_phase[k]) + 1;
      sh_phase[k] = (nx >= period_of(k)) ? '0 : PER_W'(nx);
    end
    s.time_now   = sh_slot_time;
    s.task_index = (pick >= 0) ? OUT_IDX_W'(pick) : '0;
    s.idle       = (pick < 0);
    if ({1'b0, sh_slot_time} + 33'd1 >= {1'b0, sh_hyper}) begin
      s.period_end = 1'b1;
      sh_slot_time = '0;
    end else begin
      s.period_end = 1'b0;
      sh_slot_time = sh_slot_time + 1'b1;
    end
    return s;
  endfunction

  // Send one tick word; returns right after the accepting edge
  task automatic push_tick(input logic restart);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(0, 99) < src_idle_pct) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= IN_DATA_W'(restart);
    do @(posedge clk_i); while (!s_axis_tready_o);
    slot_q.push_back(schedule_slot(restart));
    ticks_sent++;
    if (restart) restarts_sent++;
  endtask

  // Drop valid and wait until every pending slot has come out
  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (slot_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write one register; the caller lowers the enable afterwards
  task automatic write_reg(input int idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_IDX_W'(idx);
    cfg_data_i <= value;
    @(posedge clk_i);
    if (idx == int'(REG_SCHED_MODE)) begin
      sh_mode = sched_mode_e'(value[0]);
    end else if (idx == int'(REG_TASK_COUNT)) begin
      sh_count = value[CNT_W-1:0];
    end else if (idx >= REG_TASK_WORD0 && idx < REG_SPARE_FIRST) begin
      sh_word[idx - REG_TASK_WORD0] = value;
    end
  endtask

  task automatic program_regs(input sched_mode_e mode, input logic [CNT_W-1:0] count,
                              input logic [CFG_DATA_W-1:0] w0, input logic [CFG_DATA_W-1:0] w1,
                              input logic [CFG_DATA_W-1:0] w2, input logic [CFG_DATA_W-1:0] w3);
    wait_idle();
    write_reg(REG_SCHED_MODE, CFG_DATA_W'(mode));
    write_reg(REG_TASK_COUNT, CFG_DATA_W'(count));
    write_reg(REG_TASK_WORD0 + 0, w0);
    write_reg(REG_TASK_WORD0 + 1, w1);
    write_reg(REG_TASK_WORD0 + 2, w2);
    write_reg(REG_TASK_WORD0 + 3, w3);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    settings_used++;
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_task_word();
    if ($urandom_range(0, 9) < 7)
      return {EXEC_W'($urandom_range(0, 3)), PER_W'($urandom_range(1, 6))};
    return CFG_DATA_W'($urandom_range(0, 65535));
  endfunction

  // Random mode, count and task words; counts outside 1..4 now and then
  task automatic randomize_regs();
    logic [CNT_W-1:0] count;
    int               r;
    if ($urandom_range(0, 99) < 85) begin
      count = CNT_W'($urandom_range(1, MAX_TASKS));
    end else begin
      r = $urandom_range(0, 3);
      count = (r == 0) ? '0 : CNT_W'(r + 4);
    end
    program_regs(sched_mode_e'($urandom_range(0, 1)), count, pick_task_word(),
                 pick_task_word(), pick_task_word(), pick_task_word());
  endtask

  // Hold the receiver ready line according to the current idle rate
  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  // Compare each delivered slot with the oldest prediction
  always @(posedge clk_i) begin
    slot_t got;
    slot_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.time_now   = m_axis_tdata_o[TIME_W-1:0];
      got.task_index = m_axis_tdata_o[TIME_W +: OUT_IDX_W];
      got.idle       = m_axis_tuser_o;
      got.period_end = m_axis_tlast_o;
      slots_seen++;
      if (got.idle) idle_seen++;
      if (got.period_end) wraps_seen++;
      if (slot_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX)
          $display("unexpected slot: time %0d task %0d idle %0b end %0b",
                   got.time_now, got.task_index, got.idle, got.period_end);
      end else begin
        want = slot_q.pop_front();
        if (got.time_now !== want.time_now || got.task_index !== want.task_index ||
            got.idle !== want.idle || got.period_end !== want.period_end) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_MAX)
            $display({"slot mismatch: exp time %0d task %0d idle %0b end %0b, ",
                      "got time %0d task %0d idle %0b end %0b"},
                     want.time_now, want.task_index, want.idle, want.period_end,
                     got.time_now, got.task_index, got.idle, got.period_end);
        end
      end
    end
  end

  // Guard against a hang
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d slots pending", cycle_cnt, slot_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Defaults out of reset: one task, period one, no restart needed
  task automatic test_reset_state();
    push_tick(1'b0);
    push_tick(1'b0);
    push_tick(1'b1);
  endtask

  // All-zero fields: count zero, period zero and execution zero
  task automatic test_zero_fields();
    program_regs(SCHED_EDF, '0, '0, '0, '0, '0);
    push_tick(1'b1);
    push_tick(1'b0);
    push_tick(1'b0);
  endtask

  // All-ones fields: count saturates, equal periods tie to task zero
  task automatic test_full_fields();
    program_regs(SCHED_RM, '1, '1, '1, '1, '1);
    push_tick(1'b1);
    repeat (3) push_tick(1'b0);
  endtask

  // Writes past the register map must leave the schedule untouched
  task automatic test_spare_index();
    wait_idle();
    for (int idx = REG_SPARE_FIRST; idx <= REG_LAST; idx++)
      write_reg(idx, CFG_DATA_W'($urandom_range(0, 65535)));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    push_tick(1'b0);
    push_tick(1'b0);
  endtask

  // EDF over a hyper-period of six, through the time wrap
  task automatic test_wrap_edf();
    program_regs(SCHED_EDF, 3'd3, {8'd2, 8'd3}, {8'd1, 8'd2}, {8'd1, 8'd6}, '0);
    push_tick(1'b1);
    repeat (7) push_tick(1'b0);
  endtask

  // Shorten periods without a restart: phases wrap, hyper-period is kept
  task automatic test_shortened_period();
    program_regs(SCHED_RM, 3'd2, {8'd1, 8'd8}, {8'd1, 8'd4}, '0, '0);
    push_tick(1'b1);
    push_tick(1'b0);
    push_tick(1'b0);
    program_regs(SCHED_RM, 3'd2, {8'd1, 8'd2}, {8'd2, 8'd1}, '0, '0);
    push_tick(1'b0);
    push_tick(1'b0);
  endtask

  // Random settings, each mostly run from a restart, with stray restarts
  task automatic test_random_schedules(input int n_ticks, input int src_pct,
                                       input int sink_pct);
    int sent;
    int seg;
    logic restart_first;
    sent = 0;
    wait_idle();
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    while (sent < n_ticks) begin
      randomize_regs();
      seg = $urandom_range(15, 40);
      restart_first = ($urandom_range(0, 9) != 0);
      for (int i = 0; i < seg; i++) begin
        push_tick((i == 0) ? restart_first : ($urandom_range(0, 39) == 0));
        sent++;
      end
    end
    wait_idle();
  endtask

  initial begin
    int drain;
    sh_mode      = SCHED_RM;
    sh_count     = CNT_W'(1);
    sh_slot_time = '0;
    sh_hyper     = TIME_W'(1);
    for (int k = 0; k < MAX_TASKS; k++) begin
      sh_word[k]     = TASK_WORD_RST;
      sh_phase[k]    = '0;
      sh_budget[k]   = '0;
      sh_deadline[k] = '0;
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_zero_fields();
    test_full_fields();
    test_spare_index();
    test_wrap_edf();
    test_shortened_period();
    test_random_schedules(230, 9, 79);
    test_random_schedules(230, 79, 9);
    test_random_schedules(230, 0, 0);

    // Drain whatever is left, then give the output stage time to settle
    s_axis_tvalid_i <= 1'b0;
    drain = 0;
    while (slot_q.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (20) @(posedge clk_i);
    if (slot_q.size() != 0) begin
      $display("%0d predicted slots never delivered", slot_q.size());
      mismatch_cnt += slot_q.size();
    end

    $display("ran %0d ticks (%0d restarts) over %0d register settings in RM and EDF",
             ticks_sent, restarts_sent, settings_used);
    $display("checked %0d slots: %0d idle, %0d hyper-period ends, %0d mismatches",
             slots_seen, idle_seen, wraps_seen, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== rm_edf_tick_scheduler.f =====
hdl/rmedf_pkg.sv
hdl/rmedf_cell.sv
hdl/rmedf_lcm.sv
hdl/rm_edf_tick_scheduler.sv
hdl/rmedf_checker.sv
verif/tb_rm_edf_tick_scheduler.sv
